@@ rtl/core/fslc_pkg.sv @@
// shared types and constants for the same-length fir convolution unit
// no dependencies
`default_nettype none

package fslc_pkg;

    localparam int MAX_TAPS     = 7;
    localparam int SAMPLE_BITS  = 16;
    localparam int COEF_BITS    = 16;
    localparam int TAP_CNT_BITS = 3;
    localparam int VALUE_BITS   = 34;
    localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
    localparam int COUNT_BITS   = 3;
    localparam int FLUSH_BITS   = (MAX_TAPS / 2 + 1 > 2) ? $clog2(MAX_TAPS / 2 + 1) : 1;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0]    COUNT_MAX     = '1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_TAP_COUNT = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_BASE = CFG_ADDR_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [VALUE_BITS-1:0]  value_t;
    typedef logic [TAP_CNT_BITS-1:0]       tap_cnt_t;

    typedef struct packed {
        logic valid;
        logic is_final;
    } stage_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/fslc_datapath.sv @@
// product and sum stages: one registered product per tap, then the exact sum
// into the output register; depends on fslc_pkg
`default_nettype none

module fslc_datapath
    import fslc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire stage_ctl_t in_ctl,
    input  wire sample_t    taps [MAX_TAPS],
    input  wire coef_t      coefs [MAX_TAPS],
    input  wire tap_cnt_t   tap_len,
    output stage_ctl_t      out_ctl,
    output value_t          out_value
);

    prod_t      prod_reg [MAX_TAPS];
    stage_ctl_t prod_ctl_reg;
    value_t     value_reg;
    value_t     value_next;
    stage_ctl_t out_ctl_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int m = 0; m < MAX_TAPS; m++) begin
                if (TAP_CNT_BITS'(m) < tap_len) begin
                    prod_reg[m] <= coefs[m] * taps[m];
                end else begin
                    prod_reg[m] <= '0;
                end
            end
            value_reg <= value_next;
        end
    end

    always_comb begin
        value_next = '0;
        for (int m = 0; m < MAX_TAPS; m++) begin
            value_next = value_next + VALUE_BITS'(prod_reg[m]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_ctl_reg <= '0;
            out_ctl_reg  <= '0;
        end else if (advance) begin
            prod_ctl_reg <= in_ctl;
            out_ctl_reg  <= prod_ctl_reg;
        end
    end

    assign out_ctl   = out_ctl_reg;
    assign out_value = value_reg;

endmodule

`default_nettype wire

@@ rtl/core/fir_same_length_convolution_unit.sv @@
// same-length fir convolution over packets, up to seven taps, exact sums
// a sample passes the tap, product and sum registers on its way to the output; one item per cycle,
// plus floor(L/2) zero samples flushed after the packet's last sample (input held off)
// the whole pipeline stalls while an output waits on m_tready
// reset (aresetn, synchronous, active low): window and counts cleared, L = 1,
// coef_0 = 1, other coefficients 0; depends on fslc_pkg, fslc_datapath
`default_nettype none

module fir_same_length_convolution_unit
    import fslc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_TDATA_BITS-1:0]  s_tdata,   // sample
    input  wire logic                     s_tlast,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]       m_tdata,   // value, zero filled above
    output logic                          m_tlast
);

    tap_cnt_t               tap_count_reg;
    coef_t                  coef_reg [MAX_TAPS];
    sample_t                window_reg [MAX_TAPS];
    sample_t                window_next [MAX_TAPS];
    sample_t                shifted [MAX_TAPS];
    sample_t                tap_reg [MAX_TAPS];
    logic [COUNT_BITS-1:0]  count_reg, count_next, count_inc;
    logic [FLUSH_BITS-1:0]  flush_reg, flush_next;
    sample_t                shift_val;
    stage_ctl_t             ctl_next, ctl_reg, out_ctl;
    value_t                 out_value;
    tap_cnt_t               tap_len;
    logic [FLUSH_BITS-1:0]  half_len;
    logic                   advance;

    assign tap_len  = (tap_count_reg == '0) ? TAP_CNT_BITS'(1) : tap_count_reg;
    assign half_len = FLUSH_BITS'(tap_len >> 1);
    assign advance  = !out_ctl.valid || m_tready;
    assign s_tready = advance && (flush_reg == '0);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_CNT_BITS'(1);
            for (int m = 0; m < MAX_TAPS; m++) begin
                coef_reg[m] <= (m == 0) ? COEF_BITS'(1) : '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TAP_COUNT: begin
                    tap_count_reg <= cfg_wdata[TAP_CNT_BITS-1:0];
                end
                default: begin
                    coef_reg[cfg_addr - REG_COEF_BASE] <= cfg_wdata[COEF_BITS-1:0];
                end
            endcase
        end
    end

    always_comb begin
        count_inc  = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
        shift_val  = sample_t'(s_tdata[SAMPLE_BITS-1:0]);
        count_next = count_reg;
        flush_next = flush_reg;
        ctl_next   = '0;
        if (flush_reg != '0) begin
            shift_val = '0;
        end
        shifted[0] = shift_val;
        for (int i = 1; i < MAX_TAPS; i++) begin
            shifted[i] = window_reg[i-1];
        end
        window_next = window_reg;
        if (flush_reg != '0) begin
            // zero padding past the end of the packet
            ctl_next.valid    = COUNT_BITS'(flush_reg) <= count_reg;
            ctl_next.is_final = (flush_reg == FLUSH_BITS'(1));
            flush_next        = flush_reg - 1'b1;
            if (flush_reg == FLUSH_BITS'(1)) begin
                window_next = '{default: '0};
                count_next  = '0;
            end else begin
                window_next = shifted;
            end
        end else if (s_tvalid) begin
            ctl_next.valid = count_inc > COUNT_BITS'(half_len);
            if (s_tlast && half_len == '0) begin
                ctl_next.is_final = 1'b1;
                window_next       = '{default: '0};
                count_next        = '0;
            end else begin
                window_next = shifted;
                count_next  = count_inc;
                if (s_tlast) begin
                    flush_next = half_len;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '{default: '0};
            count_reg  <= '0;
            flush_reg  <= '0;
            ctl_reg    <= '0;
        end else if (advance) begin
            window_reg <= window_next;
            count_reg  <= count_next;
            flush_reg  <= flush_next;
            ctl_reg    <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tap_reg <= shifted;
        end
    end

    fslc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_ctl    (ctl_reg),
        .taps      (tap_reg),
        .coefs     (coef_reg),
        .tap_len   (tap_len),
        .out_ctl   (out_ctl),
        .out_value (out_value)
    );

    assign m_tvalid = out_ctl.valid;
    assign m_tlast  = out_ctl.is_final;
    assign m_tdata  = M_TDATA_BITS'($unsigned(out_value));

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// self-checking bench for fir_same_length_convolution_unit: packets of random
// samples against a cycle-free model of the centred fir, under varying back-pressure
// depends on fslc_pkg and the rtl of the unit
`default_nettype none

module tb;
    import fslc_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 29;

    class conv_tracker;
        typedef struct packed {
            value_t value;
            logic   is_final;
        } owed_t;

        tap_cnt_t    taps;
        coef_t       coefs [MAX_TAPS];
        longint      window [MAX_TAPS];
        int unsigned seen;
        owed_t       owed_outputs [$];
        int          errors;

        function new();
            taps = tap_cnt_t'(1);
            foreach (coefs[i]) coefs[i] = '0;
            coefs[0] = coef_t'(1);
            foreach (window[i]) window[i] = 0;
            seen = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_TAP_COUNT) begin
                taps = data[TAP_CNT_BITS-1:0];
            end else begin
                coefs[int'(idx - REG_COEF_BASE)] = coef_t'(data);
            end
        endfunction

        function void shift_window(longint smp);
            for (int i = MAX_TAPS - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = smp;
        endfunction

        function value_t filter_sum(int l);
            longint acc;
            acc = 0;
            for (int m = 0; m < l; m++) acc += longint'(coefs[m]) * window[m];
            return value_t'(acc);
        endfunction

        function void predict_sample(sample_t smp, logic lst);
            int    l;
            int    d;
            owed_t batch [$];
            owed_t entry;
            l = (taps == 0) ? 1 : int'(taps);
            if (l > MAX_TAPS) l = MAX_TAPS;
            d = l / 2;
            shift_window(longint'(smp));
            if (seen < 7) seen++;
            if (seen > d) begin
                entry.value = filter_sum(l);
                entry.is_final = 1'b0;
                batch = {batch, entry};
            end
            if (lst) begin
                for (int j = 1; j <= d; j++) begin
                    shift_window(0);
                    if (seen + j > d) begin
                        entry.value = filter_sum(l);
                        entry.is_final = 1'b0;
                        batch = {batch, entry};
                    end
                end
                if (batch.size() > 0) batch[batch.size()-1].is_final = 1'b1;
                foreach (window[i]) window[i] = 0;
                seen = 0;
            end
            foreach (batch[i]) owed_outputs = {owed_outputs, batch[i]};
        endfunction

        function void check_output(value_t value, logic is_final);
            owed_t want;
            if (owed_outputs.size() == 0) begin
                $error("output with nothing owed: value %0d is_final %0b", value, is_final);
                errors++;
            end else begin
                want = owed_outputs.pop_front();
                if (value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, value);
                    errors++;
                end
                if (is_final !== want.is_final) begin
                    $error("is_final: expected %0b, got %0b", want.is_final, is_final);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return owed_outputs.size();
        endfunction
    endclass

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata   = '0;   // sample
    logic                     s_tlast   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_tdata;          // value, zero filled above
    logic                     m_tlast;

    int unsigned s_idle_pct = 29;
    int unsigned m_idle_pct = 45;
    int          stall_cycles = 0;
    coef_t       next_coefs [MAX_TAPS];
    conv_tracker tracker = new();

    fir_same_length_convolution_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_output(value_t'(m_tdata[VALUE_BITS-1:0]), m_tlast);
        end
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(7))
            0: return sample_t'(-32768);
            1: return sample_t'(32767);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(5))
            0: return coef_t'(-32768);
            1: return coef_t'(32767);
            default: return coef_t'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        tracker.set_reg(idx, data);
    endtask

    task automatic program_filter(input tap_cnt_t tc);
        write_reg(REG_TAP_COUNT, CFG_DATA_BITS'(tc));
        for (int i = 0; i < MAX_TAPS; i++) begin
            write_reg(REG_COEF_BASE + CFG_ADDR_BITS'(i), CFG_DATA_BITS'(next_coefs[i]));
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input sample_t smp, input logic lst);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'(smp);
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        tracker.predict_sample(smp, lst);
    endtask

    task automatic send_packet(input int len);
        for (int k = 0; k < len; k++) send_item(pick_sample(), k == len - 1);
    endtask

    // let the pipeline empty, including items that owe no output
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int       sent;
        int       len;
        tap_cnt_t tc;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity filter straight out of reset
        send_item(sample_t'(32767), 1'b0);
        send_item(sample_t'(-32768), 1'b0);
        send_item(sample_t'(0), 1'b1);

        // seven taps at the negative extreme, largest possible sums
        settle_block();
        foreach (next_coefs[i]) next_coefs[i] = coef_t'(-32768);
        program_filter(tap_cnt_t'(MAX_TAPS));
        for (int k = 0; k < MAX_TAPS; k++) send_item(sample_t'(-32768), k == MAX_TAPS - 1);

        // packets shorter than the lag
        send_item(sample_t'(32767), 1'b1);
        send_item(sample_t'(-1), 1'b0);
        send_item(sample_t'(1), 1'b1);

        // zero taps behaves as one
        settle_block();
        foreach (next_coefs[i]) next_coefs[i] = pick_coef();
        next_coefs[0] = coef_t'(32767);
        program_filter(tap_cnt_t'(0));
        send_item(sample_t'(-32768), 1'b0);
        send_item(sample_t'(32767), 1'b1);

        // coefficient change in the middle of a packet
        settle_block();
        next_coefs[0] = coef_t'(5);
        next_coefs[1] = coef_t'(-3);
        next_coefs[2] = coef_t'(7);
        program_filter(tap_cnt_t'(3));
        send_item(sample_t'(1000), 1'b0);
        send_item(sample_t'(-2000), 1'b0);
        send_item(sample_t'(3000), 1'b0);
        settle_block();
        write_reg(REG_COEF_BASE + CFG_ADDR_BITS'(1), CFG_DATA_BITS'(coef_t'(-32768)));
        cfg_we <= 1'b0;
        send_item(sample_t'(-4000), 1'b0);
        send_item(sample_t'(5000), 1'b1);

        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    s_idle_pct = 29;
                    m_idle_pct = 45;
                end
                1: begin
                    s_idle_pct = 45;
                    m_idle_pct = 29;
                end
                default: begin
                    s_idle_pct = 0;
                    m_idle_pct = 0;
                end
            endcase
            for (int sub = 0; sub < 3; sub++) begin
                settle_block();
                foreach (next_coefs[i]) next_coefs[i] = pick_coef();
                tc = (sub == 0) ? tap_cnt_t'(MAX_TAPS) : tap_cnt_t'($urandom_range(0, 7));
                program_filter(tc);
                sent = 0;
                while (sent < PHASE_ITEMS) begin
                    len = ($urandom_range(4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 10);
                    send_packet(len);
                    sent += len;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
